/* hdl/arpts_pkg.sv */
package arpts_pkg;

  localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] CNT_MAX   = 32'hFFFF_FFFF;
  localparam logic [47:0] BYTES_MAX = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    ARP_NONE  = 2'd0,
    ARP_REQ   = 2'd1,
    ARP_RSP   = 2'd2,
    ARP_OTHER = 2'd3
  } arp_kind_e;

  typedef enum logic [1:0] {
    CFG_OWN_MAC           = 2'd0,
    CFG_OWN_MAC_VALID     = 2'd1,
    CFG_GATEWAY_MAC       = 2'd2,
    CFG_GATEWAY_MAC_VALID = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPD_SRC,
    ST_UPD_DST
  } back_state_e;

  typedef struct packed {
    logic [47:0] source_mac;
    logic [47:0] dest_mac;
    arp_kind_e   arp_kind;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
    logic [15:0] frame_len;
  } in_word_t;

  typedef struct packed {
    logic [31:0] frame_total;
    logic [31:0] arp_total;
    logic [6:0]  distinct_macs;
    logic [31:0] broadcast_total;
    logic [31:0] broadcast_arp_total;
    logic [31:0] gratuitous_total;
    logic [31:0] matched_pairs;
    logic [47:0] gateway_bytes;
    logic        mac_overflow;
    logic        pending_overflow;
  } out_word_t;

  typedef struct packed {
    logic [47:0] src;
    logic [47:0] dst;
    logic [63:0] key;
    logic [15:0] len;
    logic        src_bcast;
    logic        dst_bcast;
    logic        is_arp;
    logic        is_request;
    logic        is_gratuitous;
    logic        is_reply;
    logic        add_bytes;
    logic        dst_is_src;
  } cmd_t;

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == CNT_MAX) ? v : v + 32'd1;
  endfunction

endpackage

/* hdl/arpts_front.sv */
module arpts_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  arpts_pkg::in_word_t in_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [47:0]        cfg_data_i,
  input  logic               pop_i,
  output logic               avail_o,
  output arpts_pkg::cmd_t    cmd_o
);
  import arpts_pkg::*;

  logic [47:0] own_mac_q;
  logic        own_valid_q;
  logic [47:0] gw_mac_q;
  logic        gw_valid_q;

  cmd_t        cmd_d;
  cmd_t        fifo_q [2];
  logic        wr_ptr_q;
  logic        rd_ptr_q;
  logic [1:0]  count_q;
  logic [1:0]  count_d;
  logic        push;
  logic        pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_mac_q   <= '0;
      own_valid_q <= 1'b0;
      gw_mac_q    <= '0;
      gw_valid_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_OWN_MAC:           own_mac_q   <= cfg_data_i;
        CFG_OWN_MAC_VALID:     own_valid_q <= cfg_data_i[0];
        CFG_GATEWAY_MAC:       gw_mac_q    <= cfg_data_i;
        CFG_GATEWAY_MAC_VALID: gw_valid_q  <= cfg_data_i[0];
      endcase
    end
  end

  // The request key holds the target in the upper half; a reply looks for the swapped pair.
  always_comb begin
    cmd_d.src           = in_i.source_mac;
    cmd_d.dst           = in_i.dest_mac;
    cmd_d.len           = in_i.frame_len;
    cmd_d.src_bcast     = (in_i.source_mac == BCAST_MAC);
    cmd_d.dst_bcast     = (in_i.dest_mac == BCAST_MAC);
    cmd_d.is_arp        = (in_i.arp_kind != ARP_NONE);
    cmd_d.is_gratuitous = (in_i.arp_kind == ARP_REQ) &&
                          (in_i.sender_ip == in_i.target_ip);
    cmd_d.is_request    = (in_i.arp_kind == ARP_REQ) &&
                          (in_i.sender_ip != in_i.target_ip);
    cmd_d.is_reply      = (in_i.arp_kind == ARP_RSP);
    cmd_d.key           = cmd_d.is_reply ? {in_i.sender_ip, in_i.target_ip}
                                         : {in_i.target_ip, in_i.sender_ip};
    cmd_d.add_bytes     = own_valid_q && gw_valid_q &&
                          ((in_i.source_mac == own_mac_q) || (in_i.dest_mac == own_mac_q)) &&
                          ((in_i.source_mac == gw_mac_q) || (in_i.dest_mac == gw_mac_q));
    cmd_d.dst_is_src    = (in_i.dest_mac == in_i.source_mac);
  end

  assign busy_o  = (count_q == 2'd2);
  assign avail_o = (count_q != 2'd0);
  assign push    = start_i && !busy_o;
  assign pop     = pop_i && avail_o;
  assign cmd_o   = fifo_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_d;
    end
  end

endmodule

/* hdl/arpts_back.sv */
module arpts_back #(
  parameter int MAC_TABLE_DEPTH = 64,
  parameter int PENDING_DEPTH   = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 avail_i,
  input  arpts_pkg::cmd_t      cmd_i,
  output logic                 pop_o,
  output logic                 result_valid_o,
  output arpts_pkg::out_word_t result_o
);
  import arpts_pkg::*;

  localparam int MAC_AW  = $clog2(MAC_TABLE_DEPTH);
  localparam int PEND_AW = $clog2(PENDING_DEPTH);
  localparam int FILL_W  = $clog2(MAC_TABLE_DEPTH + 1);
  localparam int SCAN_N  = (MAC_TABLE_DEPTH > PENDING_DEPTH) ? MAC_TABLE_DEPTH : PENDING_DEPTH;
  localparam int SCAN_W  = $clog2(SCAN_N);
  localparam int CMP_W   = SCAN_W + FILL_W;
  localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(SCAN_N - 1);

  back_state_e         state_q;
  back_state_e         state_d;
  logic [SCAN_W-1:0]   scan_q;
  cmd_t                cmd_q;

  logic [47:0]         mac_mem [MAC_TABLE_DEPTH];
  logic [63:0]         pend_mem [PENDING_DEPTH];
  logic                pend_valid_q [PENDING_DEPTH];

  logic [47:0]         mac_rd_q;
  logic [63:0]         pend_rd_q;
  logic                pvld_rd_q;
  logic                stg_vld_q;
  logic                stg_mac_q;
  logic                stg_pend_q;
  logic [SCAN_W-1:0]   stg_idx_q;

  logic                src_hit_q;
  logic                dst_hit_q;
  logic                free_found_q;
  logic [PEND_AW-1:0]  free_idx_q;
  logic                match_found_q;
  logic [PEND_AW-1:0]  match_idx_q;
  logic                src_ins_q;

  logic [FILL_W-1:0]   fill_q;
  logic [FILL_W+6:0]   fill_ext;
  logic [31:0]         frame_q;
  logic [31:0]         arp_q;
  logic [31:0]         bcast_q;
  logic [31:0]         bcast_arp_q;
  logic [31:0]         grat_q;
  logic [31:0]         pair_q;
  logic [47:0]         bytes_q;
  logic [48:0]         bytes_sum;
  logic                mac_ovf_q;
  logic                pend_ovf_q;
  logic                res_vld_q;

  logic [MAC_AW-1:0]   mac_addr;
  logic [PEND_AW-1:0]  pend_addr;
  logic                mac_live;
  logic                pend_live;
  logic                room;
  logic                src_new;
  logic                dst_new;
  logic                mac_we;
  logic [47:0]         mac_wdata;
  logic                pend_we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (avail_i) begin
          pop_o   = 1'b1;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_q == SCAN_LAST) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN:   state_d = ST_UPD_SRC;
      ST_UPD_SRC: state_d = ST_UPD_DST;
      ST_UPD_DST: state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  assign mac_addr  = scan_q[MAC_AW-1:0];
  assign pend_addr = scan_q[PEND_AW-1:0];
  assign mac_live  = (CMP_W'(scan_q) < CMP_W'(fill_q));
  assign pend_live = (32'(scan_q) < 32'(PENDING_DEPTH));
  assign room      = (32'(fill_q) < 32'(MAC_TABLE_DEPTH));
  assign src_new   = !cmd_q.src_bcast && !src_hit_q;
  // A destination equal to a source that was just entered is already present.
  assign dst_new   = !cmd_q.dst_bcast && !dst_hit_q && !(src_ins_q && cmd_q.dst_is_src);
  assign mac_we    = room && (((state_q == ST_UPD_SRC) && src_new) ||
                              ((state_q == ST_UPD_DST) && dst_new));
  assign mac_wdata = (state_q == ST_UPD_SRC) ? cmd_q.src : cmd_q.dst;
  assign pend_we   = (state_q == ST_UPD_SRC) && cmd_q.is_request && free_found_q;
  assign bytes_sum = {1'b0, bytes_q} + 49'(cmd_q.len);

  always_ff @(posedge clk_i) begin
    if (mac_we) begin
      mac_mem[fill_q[MAC_AW-1:0]] <= mac_wdata;
    end
    if ((state_q == ST_SCAN) && mac_live) begin
      mac_rd_q <= mac_mem[mac_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_we) begin
      pend_mem[free_idx_q] <= cmd_q.key;
    end
    if ((state_q == ST_SCAN) && pend_live) begin
      pend_rd_q <= pend_mem[pend_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q        <= '0;
      pvld_rd_q     <= 1'b0;
      stg_vld_q     <= 1'b0;
      stg_mac_q     <= 1'b0;
      stg_pend_q    <= 1'b0;
      stg_idx_q     <= '0;
      src_hit_q     <= 1'b0;
      dst_hit_q     <= 1'b0;
      free_found_q  <= 1'b0;
      free_idx_q    <= '0;
      match_found_q <= 1'b0;
      match_idx_q   <= '0;
      src_ins_q     <= 1'b0;
      fill_q        <= '0;
      frame_q       <= '0;
      arp_q         <= '0;
      bcast_q       <= '0;
      bcast_arp_q   <= '0;
      grat_q        <= '0;
      pair_q        <= '0;
      bytes_q       <= '0;
      mac_ovf_q     <= 1'b0;
      pend_ovf_q    <= 1'b0;
      res_vld_q     <= 1'b0;
      for (int i = 0; i < PENDING_DEPTH; i++) begin
        pend_valid_q[i] <= 1'b0;
      end
    end else begin
      stg_vld_q  <= (state_q == ST_SCAN);
      stg_mac_q  <= mac_live;
      stg_pend_q <= pend_live;
      stg_idx_q  <= scan_q;
      res_vld_q  <= (state_q == ST_UPD_DST);

      if (pop_o) begin
        scan_q        <= '0;
        src_hit_q     <= 1'b0;
        dst_hit_q     <= 1'b0;
        free_found_q  <= 1'b0;
        match_found_q <= 1'b0;
        src_ins_q     <= 1'b0;
      end

      if (state_q == ST_SCAN) begin
        scan_q <= scan_q + SCAN_W'(1);
        if (pend_live) begin
          pvld_rd_q <= pend_valid_q[pend_addr];
        end
      end

      if (stg_vld_q) begin
        if (stg_mac_q) begin
          if (mac_rd_q == cmd_q.src) begin
            src_hit_q <= 1'b1;
          end
          if (mac_rd_q == cmd_q.dst) begin
            dst_hit_q <= 1'b1;
          end
        end
        if (stg_pend_q) begin
          if (!pvld_rd_q && !free_found_q) begin
            free_found_q <= 1'b1;
            free_idx_q   <= stg_idx_q[PEND_AW-1:0];
          end
          if (pvld_rd_q && (pend_rd_q == cmd_q.key) && !match_found_q) begin
            match_found_q <= 1'b1;
            match_idx_q   <= stg_idx_q[PEND_AW-1:0];
          end
        end
      end

      if (state_q == ST_UPD_SRC) begin
        frame_q <= sat_inc(frame_q);
        if (cmd_q.dst_bcast) begin
          bcast_q <= sat_inc(bcast_q);
        end
        if (cmd_q.is_arp) begin
          arp_q <= sat_inc(arp_q);
          if (cmd_q.dst_bcast) begin
            bcast_arp_q <= sat_inc(bcast_arp_q);
          end
        end
        if (cmd_q.is_gratuitous) begin
          grat_q <= sat_inc(grat_q);
        end
        if (cmd_q.is_request) begin
          if (free_found_q) begin
            pend_valid_q[free_idx_q] <= 1'b1;
          end else begin
            pend_ovf_q <= 1'b1;
          end
        end
        if (cmd_q.is_reply && match_found_q) begin
          pend_valid_q[match_idx_q] <= 1'b0;
          pair_q <= sat_inc(pair_q);
        end
        if (cmd_q.add_bytes) begin
          bytes_q <= bytes_sum[48] ? BYTES_MAX : bytes_sum[47:0];
        end
        if (src_new) begin
          if (room) begin
            fill_q    <= fill_q + FILL_W'(1);
            src_ins_q <= 1'b1;
          end else begin
            mac_ovf_q <= 1'b1;
          end
        end
      end

      if ((state_q == ST_UPD_DST) && dst_new) begin
        if (room) begin
          fill_q <= fill_q + FILL_W'(1);
        end else begin
          mac_ovf_q <= 1'b1;
        end
      end
    end
  end

  assign fill_ext = {7'd0, fill_q};

  assign result_valid_o               = res_vld_q;
  assign result_o.frame_total         = frame_q;
  assign result_o.arp_total           = arp_q;
  assign result_o.distinct_macs       = fill_ext[6:0];
  assign result_o.broadcast_total     = bcast_q;
  assign result_o.broadcast_arp_total = bcast_arp_q;
  assign result_o.gratuitous_total    = grat_q;
  assign result_o.matched_pairs       = pair_q;
  assign result_o.gateway_bytes       = bytes_q;
  assign result_o.mac_overflow        = mac_ovf_q;
  assign result_o.pending_overflow    = pend_ovf_q;

endmodule

/* hdl/arp_traffic_statistics_top.sv */
// ARP traffic statistics: one word per Ethernet frame header goes in on start while busy is
// low, and each word yields one result_valid_o strobe, one cycle long, with a snapshot of all
// counters on result_o; the receiver cannot stall it. A two-word input queue sits in front of
// the engine, so busy rises only when two words wait. Each word makes one pass in the engine that
// reads the MAC table and the pending request table one entry per cycle through their single
// read ports, over max(MAC_TABLE_DEPTH, PENDING_DEPTH) entries, followed by the update states
// that write the source entry and then the destination entry.
// No clearing pass is needed after reset.
module arp_traffic_statistics_top #(
  parameter int MAC_TABLE_DEPTH = 64,
  parameter int PENDING_DEPTH   = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  arpts_pkg::in_word_t  in_i,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [47:0]          cfg_data_i,
  output logic                 result_valid_o,
  output arpts_pkg::out_word_t result_o
);
  import arpts_pkg::*;

  cmd_t cmd;
  logic avail;
  logic pop;

  arpts_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .busy_o     (busy),
    .in_i       (in_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pop_i      (pop),
    .avail_o    (avail),
    .cmd_o      (cmd)
  );

  arpts_back #(
    .MAC_TABLE_DEPTH (MAC_TABLE_DEPTH),
    .PENDING_DEPTH   (PENDING_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .avail_i        (avail),
    .cmd_i          (cmd),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

/* hdl/arpts_checker.sv */
module arpts_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input logic                 result_valid_o,
  input arpts_pkg::out_word_t result_o
);
  import arpts_pkg::*;

  // Each word passes the scan and update states before the next is taken, so strobes never come back to back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  // The queue only fills when a word is taken in.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy rose without an accepted word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (result_o.frame_total >= $past(result_o.frame_total)) &&
        (result_o.gateway_bytes >= $past(result_o.gateway_bytes)) &&
        (result_o.mac_overflow >= $past(result_o.mac_overflow)) &&
        (result_o.pending_overflow >= $past(result_o.pending_overflow)))
    else $error("a counter or sticky flag went backward");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.frame_total != 32'd0) &&
                       (result_o.arp_total <= result_o.frame_total) &&
                       (result_o.broadcast_total <= result_o.frame_total) &&
                       (result_o.broadcast_arp_total <= result_o.arp_total) &&
                       (result_o.broadcast_arp_total <= result_o.broadcast_total) &&
                       (result_o.gratuitous_total <= result_o.arp_total) &&
                       (result_o.matched_pairs <= result_o.arp_total))
    else $error("counters in a result are inconsistent");

endmodule

bind arp_traffic_statistics_top arpts_checker u_arpts_checker (.*);

/* bench/arp_traffic_statistics_top_tb.sv */
`timescale 1ns / 1ps

module arp_traffic_statistics_top_tb;
  import arpts_pkg::*;

  localparam int MAC_DEPTH       = 64;
  localparam int REQ_DEPTH       = 64;
  localparam int IDLE_LIMIT      = 4000;
  localparam int SETTLE_CYCLES   = 150;
  localparam int CONFIG_PAUSE    = 80;
  localparam int PHASES          = 7;
  localparam int ITEMS_PER_PHASE = 200;

  typedef struct {
    in_word_t    word;
    int unsigned gap;
  } frame_slot_t;

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        start      = 1'b0;
  logic        busy;
  in_word_t    in_i       = '0;
  logic        cfg_we_i   = 1'b0;
  logic [1:0]  cfg_idx_i  = CFG_OWN_MAC;
  logic [47:0] cfg_data_i = '0;
  logic        result_valid_o;
  out_word_t   result_o;

  arp_traffic_statistics_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .in_i           (in_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // Stimulus side.
  frame_slot_t frame_queue[$];
  logic [63:0] open_requests[$];
  logic [47:0] host_macs[40];
  logic [31:0] host_ips[26];
  logic [47:0] cfg_own = '0;
  logic [47:0] cfg_gw  = '0;
  int          fresh_pct = 0;
  bit          flood = 1'b0;
  int          calm_left = 0;
  bit          calm = 1'b0;
  int unsigned gap_left = 0;
  logic        took_word = 1'b0;

  // Predicted statistics and their state.
  out_word_t   stats_due[$];
  logic [47:0] p_own_mac = '0;
  logic [47:0] p_gw_mac  = '0;
  logic        p_own_ok  = 1'b0;
  logic        p_gw_ok   = 1'b0;
  logic [31:0] n_frames = '0;
  logic [31:0] n_arp = '0;
  logic [31:0] n_bcast = '0;
  logic [31:0] n_bcast_arp = '0;
  logic [31:0] n_gratuitous = '0;
  logic [31:0] n_pairs = '0;
  logic [48:0] n_bytes = '0;
  logic [47:0] mac_seen[MAC_DEPTH];
  int          mac_fill = 0;
  logic [63:0] req_key[REQ_DEPTH];
  bit          req_live[REQ_DEPTH];
  logic        mac_full_hit = 1'b0;
  logic        req_full_hit = 1'b0;

  int          mismatches = 0;
  int          idle_cycles = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [47:0] rand48();
    logic [63:0] t;
    t = {$urandom, $urandom};
    return t[47:0];
  endfunction

  function automatic logic [31:0] bump(logic [31:0] v);
    return (v == CNT_MAX) ? v : v + 32'd1;
  endfunction

  function automatic void learn_address(logic [47:0] mac);
    if (mac == BCAST_MAC) return;
    for (int i = 0; i < mac_fill; i++) begin
      if (mac_seen[i] == mac) return;
    end
    if (mac_fill < MAC_DEPTH) begin
      mac_seen[mac_fill] = mac;
      mac_fill++;
    end else begin
      mac_full_hit = 1'b1;
    end
  endfunction

  function automatic void file_request(logic [63:0] key);
    for (int i = 0; i < REQ_DEPTH; i++) begin
      if (!req_live[i]) begin
        req_key[i] = key;
        req_live[i] = 1'b1;
        return;
      end
    end
    req_full_hit = 1'b1;
  endfunction

  function automatic void retire_request(logic [63:0] key);
    for (int i = 0; i < REQ_DEPTH; i++) begin
      if (req_live[i] && req_key[i] == key) begin
        req_live[i] = 1'b0;
        n_pairs = bump(n_pairs);
        return;
      end
    end
  endfunction

  function automatic out_word_t tally_frame(in_word_t w);
    out_word_t s;
    logic      bcast;
    bcast = (w.dest_mac == BCAST_MAC);
    n_frames = bump(n_frames);
    learn_address(w.source_mac);
    learn_address(w.dest_mac);
    if (bcast) n_bcast = bump(n_bcast);
    if (w.arp_kind != ARP_NONE) begin
      n_arp = bump(n_arp);
      if (bcast) n_bcast_arp = bump(n_bcast_arp);
      if (w.arp_kind == ARP_REQ) begin
        if (w.sender_ip == w.target_ip) begin
          n_gratuitous = bump(n_gratuitous);
        end else begin
          file_request({w.target_ip, w.sender_ip});
        end
      end else if (w.arp_kind == ARP_RSP) begin
        retire_request({w.sender_ip, w.target_ip});
      end
    end
    if (p_own_ok && p_gw_ok &&
        (w.source_mac == p_own_mac || w.dest_mac == p_own_mac) &&
        (w.source_mac == p_gw_mac || w.dest_mac == p_gw_mac)) begin
      n_bytes = n_bytes + w.frame_len;
      if (n_bytes > BYTES_MAX) n_bytes = BYTES_MAX;
    end
    s.frame_total         = n_frames;
    s.arp_total           = n_arp;
    s.distinct_macs       = 7'(mac_fill);
    s.broadcast_total     = n_bcast;
    s.broadcast_arp_total = n_bcast_arp;
    s.gratuitous_total    = n_gratuitous;
    s.matched_pairs       = n_pairs;
    s.gateway_bytes       = n_bytes[47:0];
    s.mac_overflow        = mac_full_hit;
    s.pending_overflow    = req_full_hit;
    return s;
  endfunction

  task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    out_word_t want;
    took_word <= rst_ni && start && !busy;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (stats_due.size() == 0) begin
          $error("result word with no frame outstanding: %h", result_o);
          mismatches++;
        end else begin
          want = stats_due.pop_front();
          check_field("frame_total", want.frame_total, result_o.frame_total);
          check_field("arp_total", want.arp_total, result_o.arp_total);
          check_field("distinct_macs", want.distinct_macs, result_o.distinct_macs);
          check_field("broadcast_total", want.broadcast_total, result_o.broadcast_total);
          check_field("broadcast_arp_total", want.broadcast_arp_total,
                      result_o.broadcast_arp_total);
          check_field("gratuitous_total", want.gratuitous_total, result_o.gratuitous_total);
          check_field("matched_pairs", want.matched_pairs, result_o.matched_pairs);
          check_field("gateway_bytes", want.gateway_bytes, result_o.gateway_bytes);
          check_field("mac_overflow", want.mac_overflow, result_o.mac_overflow);
          check_field("pending_overflow", want.pending_overflow, result_o.pending_overflow);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_OWN_MAC:           p_own_mac = cfg_data_i;
          CFG_OWN_MAC_VALID:     p_own_ok  = cfg_data_i[0];
          CFG_GATEWAY_MAC:       p_gw_mac  = cfg_data_i;
          CFG_GATEWAY_MAC_VALID: p_gw_ok   = cfg_data_i[0];
          default: ;
        endcase
      end
      if (start && !busy) stats_due.insert(stats_due.size(), tally_frame(in_i));
    end
  end

  always @(negedge clk_i) begin
    frame_slot_t slot;
    if (rst_ni && (!start || took_word)) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (frame_queue.size() != 0) begin
        slot = frame_queue.pop_front();
        in_i <= slot.word;
        start <= 1'b1;
        gap_left <= slot.gap;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("arp_traffic_statistics_top: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic in_word_t frame_of(logic [47:0] src, logic [47:0] dst, arp_kind_e kind,
                                        logic [31:0] sip, logic [31:0] tip,
                                        logic [15:0] len);
    in_word_t w;
    w.source_mac = src;
    w.dest_mac   = dst;
    w.arp_kind   = kind;
    w.sender_ip  = sip;
    w.target_ip  = tip;
    w.frame_len  = len;
    return w;
  endfunction

  task automatic queue_frame(in_word_t w);
    frame_slot_t slot;
    if (calm_left == 0) begin
      calm_left = $urandom_range(10, 60);
      calm = ($urandom_range(0, 3) == 0);
    end
    calm_left--;
    slot.word = w;
    slot.gap  = calm ? 0 : $urandom_range(0, 19);
    frame_queue.insert(frame_queue.size(), slot);
  endtask

  function automatic logic [47:0] pick_mac();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return cfg_own;
    if (r < 24) return cfg_gw;
    if (r < 34) return BCAST_MAC;
    if (r < 37) return '0;
    if (r < 37 + fresh_pct) return rand48();
    return host_macs[$urandom_range(0, $size(host_macs) - 1)];
  endfunction

  function automatic logic [31:0] pick_ip();
    if ($urandom_range(0, 99) < 85) return host_ips[$urandom_range(0, $size(host_ips) - 1)];
    return $urandom;
  endfunction

  task automatic queue_random_frame();
    in_word_t    w;
    logic [63:0] pair;
    int          r;
    int          k;
    int          pick;
    w.source_mac = pick_mac();
    w.dest_mac   = pick_mac();
    w.sender_ip  = $urandom;
    w.target_ip  = $urandom;
    r = $urandom_range(0, 99);
    w.frame_len = (r < 5) ? 16'h0000 : (r < 10) ? 16'hFFFF : 16'($urandom);
    r = $urandom_range(0, 99);
    if (r < (flood ? 10 : 25)) begin
      w.arp_kind = ARP_NONE;
    end else if (r < (flood ? 75 : 55)) begin
      w.arp_kind = ARP_REQ;
      if ($urandom_range(0, 3) != 0) w.dest_mac = BCAST_MAC;
      w.sender_ip = pick_ip();
      w.target_ip = ($urandom_range(0, 9) == 0) ? w.sender_ip : pick_ip();
      if (w.sender_ip != w.target_ip) begin
        open_requests.insert(open_requests.size(), {w.sender_ip, w.target_ip});
        if (open_requests.size() > 300) void'(open_requests.pop_front());
      end
    end else if (r < 90) begin
      w.arp_kind  = ARP_RSP;
      w.sender_ip = pick_ip();
      w.target_ip = pick_ip();
      k = $urandom_range(0, 9);
      if (open_requests.size() != 0 && k < 8) begin
        pick = $urandom_range(0, open_requests.size() - 1);
        pair = open_requests[pick];
        if (k < 6) begin
          w.sender_ip = pair[31:0];
          w.target_ip = pair[63:32];
          open_requests.delete(pick);
        end else if (k == 6) begin
          w.sender_ip = pair[63:32];
          w.target_ip = pair[31:0];
        end else begin
          w.sender_ip = pair[31:0];
        end
      end
    end else begin
      w.arp_kind = ARP_OTHER;
    end
    queue_frame(w);
  endtask

  task automatic wait_quiet();
    do @(posedge clk_i);
    while (frame_queue.size() != 0 || start || stats_due.size() != 0);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [47:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic apply_setting(logic [47:0] own, logic own_v, logic [47:0] gw, logic gw_v);
    logic [47:0] t;
    cfg_own = own;
    cfg_gw  = gw;
    write_reg(CFG_OWN_MAC, own);
    t = rand48();
    t[0] = own_v;
    write_reg(CFG_OWN_MAC_VALID, t);
    write_reg(CFG_GATEWAY_MAC, gw);
    t = rand48();
    t[0] = gw_v;
    write_reg(CFG_GATEWAY_MAC_VALID, t);
  endtask

  initial begin
    logic [31:0] ip_a;
    logic [31:0] ip_b;
    logic [31:0] ip_c;
    logic [47:0] shared_mac;
    foreach (host_macs[i]) host_macs[i] = rand48();
    foreach (host_ips[i]) host_ips[i] = $urandom;
    host_ips[24] = '0;
    host_ips[25] = '1;
    ip_a = host_ips[0];
    ip_b = host_ips[1];
    ip_c = host_ips[2];

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening with the reset configuration, where byte counting is off.
    queue_frame(frame_of('0, BCAST_MAC, ARP_NONE, '1, '0, 16'h0000));
    queue_frame(frame_of(BCAST_MAC, host_macs[0], ARP_NONE, '0, '1, 16'hFFFF));
    queue_frame(frame_of(host_macs[1], host_macs[1], ARP_OTHER, ip_a, ip_b, 16'd60));
    queue_frame(frame_of(host_macs[2], BCAST_MAC, ARP_OTHER, ip_c, ip_c, 16'd64));
    queue_frame(frame_of(host_macs[3], BCAST_MAC, ARP_REQ, ip_a, ip_b, 16'd60));
    queue_frame(frame_of(host_macs[3], BCAST_MAC, ARP_REQ, ip_a, ip_b, 16'd60));
    queue_frame(frame_of(host_macs[4], BCAST_MAC, ARP_REQ, ip_c, ip_c, 16'd60));
    queue_frame(frame_of(host_macs[4], host_macs[5], ARP_REQ, '0, '0, 16'd60));
    queue_frame(frame_of(host_macs[5], BCAST_MAC, ARP_REQ, '1, '1, 16'd60));
    queue_frame(frame_of(host_macs[6], host_macs[3], ARP_RSP, ip_b, ip_a, 16'd60));
    queue_frame(frame_of(host_macs[6], host_macs[3], ARP_RSP, ip_b, ip_a, 16'd60));
    queue_frame(frame_of(host_macs[6], host_macs[3], ARP_RSP, ip_b, ip_a, 16'd60));
    queue_frame(frame_of(host_macs[3], BCAST_MAC, ARP_REQ, ip_a, ip_b, 16'd60));
    queue_frame(frame_of(host_macs[6], host_macs[3], ARP_RSP, ip_a, ip_b, 16'd60));
    queue_frame(frame_of(host_macs[6], host_macs[3], ARP_RSP, ip_b, ip_c, 16'd60));
    queue_frame(frame_of(host_macs[6], host_macs[3], ARP_RSP, ip_b, ip_a, 16'd60));
    queue_frame(frame_of(host_macs[7], BCAST_MAC, ARP_REQ, '0, '1, 16'd42));
    queue_frame(frame_of(host_macs[8], host_macs[7], ARP_RSP, '1, '0, 16'd42));
    queue_frame(frame_of(host_macs[8], host_macs[7], ARP_RSP, ip_c, ip_c, 16'd42));
    queue_frame(frame_of(host_macs[9], host_macs[8], ARP_NONE, ip_a, ip_a, 16'd1500));
    queue_frame(frame_of('0, '0, ARP_NONE, ip_a, ip_b, 16'hFFFF));

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        wait_quiet();
        repeat (CONFIG_PAUSE) @(posedge clk_i);
        case (phase)
          1: apply_setting(rand48(), 1'b1, rand48(), 1'b1);
          2: apply_setting('0, 1'b1, '1, 1'b1);
          3: apply_setting('1, 1'b1, '0, 1'b1);
          4: apply_setting(rand48(), 1'b1, rand48(), 1'b0);
          5: apply_setting(rand48(), 1'b0, rand48(), 1'b1);
          default: begin
            shared_mac = rand48();
            apply_setting(shared_mac, 1'b1, shared_mac, 1'b1);
          end
        endcase
      end
      fresh_pct = (phase >= 5) ? 12 : 0;
      flood = (phase == 3);
      repeat (ITEMS_PER_PHASE) queue_random_frame();
    end

    wait_quiet();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && stats_due.size() == 0) begin
      $display("arp_traffic_statistics_top: match");
    end else begin
      if (stats_due.size() != 0) $error("%0d result words never arrived", stats_due.size());
      $display("arp_traffic_statistics_top: mismatch");
    end
    $finish;
  end

endmodule
